### design/mlsc_pkg.sv
`timescale 1ns / 1ps

package mlsc_pkg;

  // Item field widths
  localparam int MOTION_W = 16;
  localparam int COLOR_W  = 8;
  localparam int X_W      = 9;
  localparam int Y_W      = 8;
  localparam int SAL_W    = 8;

  // State widths
  localparam int VAL_W    = 24;  // integrator entry, unsigned 8.16
  localparam int CNT_W    = 18;
  localparam int SUMX_W   = 26;
  localparam int SUMY_W   = 25;
  localparam int POS_W    = 11;  // signed last published position
  localparam int JUMP_W   = 10;
  localparam int COEF_W   = 16;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COLOR_THR   = 3'd0,
    CFG_MOTION_SAT  = 3'd1,
    CFG_INPUT_GAIN  = 3'd2,
    CFG_LEAK        = 3'd3,
    CFG_DETECT_THR  = 3'd4,
    CFG_MIN_JUMP    = 3'd5
  } cfg_idx_e;

  localparam logic [COLOR_W-1:0]  RST_COLOR_THR  = 8'd30;
  localparam logic [MOTION_W-1:0] RST_MOTION_SAT = 16'd12800;
  localparam logic [COEF_W-1:0]   RST_INPUT_GAIN = 16'd3277;
  localparam logic [COEF_W-1:0]   RST_LEAK       = 16'd65529;
  localparam logic [MOTION_W-1:0] RST_DETECT_THR = 16'd23040;
  localparam logic [JUMP_W-1:0]   RST_MIN_JUMP   = 10'd25;

  // Integrator ceiling: 255.0 in 8.16
  localparam logic [VAL_W-1:0] VAL_MAX = 24'hFF0000;

  // Last published position after reset
  localparam logic signed [POS_W-1:0] POS_RESET = -11'sd1000;

  typedef struct packed {
    logic           vld;
    logic           rep;
    logic [X_W-1:0] x;
    logic [Y_W-1:0] y;
  } centroid_t;

endpackage

### design/mlsc_pixel_if.sv
`timescale 1ns / 1ps

interface mlsc_pixel_if import mlsc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [MOTION_W-1:0] motion_salience;
  logic [COLOR_W-1:0]  color_salience;
  logic [X_W-1:0]      pixel_x;
  logic [Y_W-1:0]      pixel_y;
  logic                frame_end;

  modport source (
    output valid, motion_salience, color_salience, pixel_x, pixel_y, frame_end,
    input  ready
  );
  modport sink (
    input  valid, motion_salience, color_salience, pixel_x, pixel_y, frame_end,
    output ready
  );
endinterface

### design/mlsc_result_if.sv
`timescale 1ns / 1ps

interface mlsc_result_if import mlsc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [SAL_W-1:0] salience_out;
  logic             centroid_valid;
  logic             centroid_reported;
  logic [X_W-1:0]   centroid_x;
  logic [Y_W-1:0]   centroid_y;

  modport source (
    output valid, salience_out, centroid_valid, centroid_reported, centroid_x, centroid_y,
    input  ready
  );
  modport sink (
    input  valid, salience_out, centroid_valid, centroid_reported, centroid_x, centroid_y,
    output ready
  );
endinterface

### design/mlsc_cfg_if.sv
`timescale 1ns / 1ps

interface mlsc_cfg_if import mlsc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### design/mlsc_frame_ram.sv
`timescale 1ns / 1ps

module mlsc_frame_ram import mlsc_pkg::*; #(
  parameter int DEPTH = 131072,
  parameter int AW    = 17
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic             we_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [VAL_W-1:0] wdata_i,
  output logic [VAL_W-1:0] rdata_o
);

  logic [VAL_W-1:0] mem [DEPTH];
  logic [VAL_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/mlsc_divider.sv
`timescale 1ns / 1ps

module mlsc_divider import mlsc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [SUMX_W-1:0] dividend_i,
  input  logic [CNT_W-1:0]  divisor_i,
  output logic              done_o,
  output logic [SUMX_W-1:0] quotient_o
);

  localparam int STEP_W = $clog2(SUMX_W + 1);

  logic              busy_q, done_q;
  logic [STEP_W-1:0] step_q;
  logic [CNT_W-1:0]  rem_q, dsr_q;
  logic [SUMX_W-1:0] quo_q;

  logic [CNT_W:0] rem_sh, diff;
  logic           ge;

  // Restoring division, one quotient bit per cycle
  assign rem_sh = {rem_q, quo_q[SUMX_W-1]};
  assign diff   = rem_sh - {1'b0, dsr_q};
  assign ge     = rem_sh >= {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= STEP_W'(SUMX_W);
      end else if (busy_q) begin
        step_q <= step_q - 1'b1;
        if (step_q == STEP_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
      quo_q <= {quo_q[SUMX_W-2:0], ge};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

### design/mlsc_centroid.sv
`timescale 1ns / 1ps

module mlsc_centroid import mlsc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [CNT_W-1:0]  count_i,
  input  logic [SUMX_W-1:0] sumx_i,
  input  logic [SUMY_W-1:0] sumy_i,
  input  logic [JUMP_W-1:0] min_jump_i,
  output logic              done_o,
  output centroid_t         cen_o
);

  localparam int D_W  = POS_W + 1;      // signed distance
  localparam int SQ_W = 2 * D_W;
  localparam int D2_W = 2 * POS_W;      // squared distance fits here
  localparam int LM_W = 2 * JUMP_W;

  typedef enum logic [1:0] {C_IDLE, C_DIV, C_SQR, C_CMP} c_state_e;

  c_state_e state_q;
  logic     done_q;
  centroid_t cen_q;
  logic signed [POS_W-1:0] last_x_q, last_y_q;
  logic [X_W-1:0]  cx_q;
  logic [Y_W-1:0]  cy_q;
  logic [D2_W-1:0] dx2_q, dy2_q;
  logic [LM_W-1:0] lim_q;

  logic              div_start, dx_done, dy_done;
  logic [SUMX_W-1:0] qx, qy;
  logic signed [D_W-1:0]  dx, dy;
  logic signed [SQ_W-1:0] dx_sq, dy_sq;
  logic [D2_W:0]          d2;

  assign div_start = start_i && (count_i != '0);

  mlsc_divider u_div_x (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sumx_i),
    .divisor_i  (count_i),
    .done_o     (dx_done),
    .quotient_o (qx)
  );

  mlsc_divider u_div_y (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (SUMX_W'(sumy_i)),
    .divisor_i  (count_i),
    .done_o     (dy_done),
    .quotient_o (qy)
  );

  assign dx    = $signed(D_W'(cx_q)) - $signed({last_x_q[POS_W-1], last_x_q});
  assign dy    = $signed(D_W'(cy_q)) - $signed({last_y_q[POS_W-1], last_y_q});
  assign dx_sq = SQ_W'(dx) * SQ_W'(dx);
  assign dy_sq = SQ_W'(dy) * SQ_W'(dy);
  assign d2    = (D2_W + 1)'(dx2_q) + (D2_W + 1)'(dy2_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= C_IDLE;
      done_q   <= 1'b0;
      cen_q    <= '0;
      last_x_q <= POS_RESET;
      last_y_q <= POS_RESET;
      cx_q     <= '0;
      cy_q     <= '0;
      dx2_q    <= '0;
      dy2_q    <= '0;
      lim_q    <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        C_IDLE: begin
          if (start_i) begin
            if (count_i == '0) begin
              cen_q  <= '0;
              done_q <= 1'b1;
            end else begin
              state_q <= C_DIV;
            end
          end
        end
        C_DIV: begin
          if (dx_done && dy_done) begin
            cx_q    <= (|qx[SUMX_W-1:X_W]) ? '1 : qx[X_W-1:0];
            cy_q    <= (|qy[SUMX_W-1:Y_W]) ? '1 : qy[Y_W-1:0];
            state_q <= C_SQR;
          end
        end
        C_SQR: begin
          dx2_q   <= dx_sq[D2_W-1:0];
          dy2_q   <= dy_sq[D2_W-1:0];
          lim_q   <= LM_W'(min_jump_i) * LM_W'(min_jump_i);
          state_q <= C_CMP;
        end
        C_CMP: begin
          cen_q.vld <= 1'b1;
          cen_q.rep <= d2 > (D2_W + 1)'(lim_q);
          cen_q.x   <= cx_q;
          cen_q.y   <= cy_q;
          if (d2 > (D2_W + 1)'(lim_q)) begin
            last_x_q <= $signed(POS_W'(cx_q));
            last_y_q <= $signed(POS_W'(cy_q));
          end
          done_q  <= 1'b1;
          state_q <= C_IDLE;
        end
        default: state_q <= C_IDLE;
      endcase
    end
  end

  assign done_o = done_q;
  assign cen_o  = cen_q;

endmodule

### design/masked_leaky_salience_centroid_unit.sv
`timescale 1ns / 1ps

// Masked leaky salience centroid. Each pixel item reads its integrator entry
// from a single-port frame RAM, scales it by leak_factor, adds input_gain times
// the saturated motion salience, clamps at 255.0, gates by the color mask and
// writes it back; pixels above detect_threshold feed a count and coordinate
// sums. A pixel passes through accept and RAM read, multiply, accumulate and
// write-back, then the output register; because of the read-modify-write of
// the one RAM port, no new pixel is taken until it is through. It waits longer
// in the output stage while the previous result has not been taken. A frame-end
// pixel also runs the centroid: starting the divide, the divide itself at one
// quotient bit per cycle, then the distance check and the handoff (no divide
// is run when nothing was detected). After reset the frame RAM is cleared one
// entry per cycle, all MAX_WIDTH*MAX_HEIGHT entries, before the first pixel is
// taken. The configuration port is always ready; write it only while no pixel
// is in flight.
module masked_leaky_salience_centroid_unit import mlsc_pkg::*; #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 256
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  mlsc_pixel_if.sink    pixel_i,
  mlsc_result_if.source result_o,
  mlsc_cfg_if.sink      cfg_i
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int PI_W  = 2 * COEF_W;
  localparam int PL_W  = COEF_W + VAL_W;
  localparam int ACC_W = PL_W + 1;
  localparam int R_W   = ACC_W - COEF_W;

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_MUL, S_ACC, S_DIV, S_OUT} state_e;

  // Configuration
  logic [COLOR_W-1:0]  color_thr_q;
  logic [MOTION_W-1:0] motion_sat_q, detect_thr_q;
  logic [COEF_W-1:0]   gain_q, leak_q;
  logic [JUMP_W-1:0]   min_jump_q;

  // Control
  state_e        state_q;
  logic [AW-1:0] clr_addr_q;
  logic          cen_start_q;
  logic          out_vld_q;

  // Item payload
  logic [AW-1:0]       addr_q;
  logic [X_W-1:0]      x_q;
  logic [Y_W-1:0]      y_q;
  logic [MOTION_W-1:0] m_q;
  logic                mask_q, in_range_q, fend_q;
  logic [PI_W-1:0]     prod_in_q;
  logic [PL_W-1:0]     prod_lk_q;
  logic [SAL_W-1:0]    sal_q;

  // Accumulators
  logic [CNT_W-1:0]  cnt_q;
  logic [SUMX_W-1:0] sumx_q;
  logic [SUMY_W-1:0] sumy_q;

  // Output register
  logic [SAL_W-1:0] out_sal_q;
  centroid_t        out_cen_q;

  logic             pix_acc, pix_in_range;
  logic [AW-1:0]    pix_addr;
  logic             mem_en, mem_we;
  logic [AW-1:0]    mem_addr;
  logic [VAL_W-1:0] mem_rdata;
  logic [ACC_W-1:0] acc;
  logic [R_W-1:0]   acc_r;
  logic [VAL_W-1:0] val_d;
  logic             detect;
  logic [SUMX_W:0]  sumx_inc;
  logic [SUMY_W:0]  sumy_inc;
  logic             cen_done;
  centroid_t        cen;
  logic             out_load;

  assign pix_acc      = pixel_i.valid && pixel_i.ready;
  assign pix_in_range = (32'(pixel_i.pixel_x) < 32'(MAX_WIDTH))
                     && (32'(pixel_i.pixel_y) < 32'(MAX_HEIGHT));
  assign pix_addr     = AW'(pixel_i.pixel_y) * AW'(MAX_WIDTH) + AW'(pixel_i.pixel_x);

  assign pixel_i.ready = (state_q == S_IDLE);
  assign cfg_i.ready   = 1'b1;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_thr_q  <= RST_COLOR_THR;
      motion_sat_q <= RST_MOTION_SAT;
      gain_q       <= RST_INPUT_GAIN;
      leak_q       <= RST_LEAK;
      detect_thr_q <= RST_DETECT_THR;
      min_jump_q   <= RST_MIN_JUMP;
    end else if (cfg_i.valid && cfg_i.ready) begin
      unique case (cfg_i.index)
        CFG_COLOR_THR:  color_thr_q  <= cfg_i.data[COLOR_W-1:0];
        CFG_MOTION_SAT: motion_sat_q <= cfg_i.data[MOTION_W-1:0];
        CFG_INPUT_GAIN: gain_q       <= cfg_i.data[COEF_W-1:0];
        CFG_LEAK:       leak_q       <= cfg_i.data[COEF_W-1:0];
        CFG_DETECT_THR: detect_thr_q <= cfg_i.data[MOTION_W-1:0];
        CFG_MIN_JUMP:   min_jump_q   <= cfg_i.data[JUMP_W-1:0];
        default: ;
      endcase
    end
  end

  // Frame RAM access
  always_comb begin
    mem_en   = 1'b0;
    mem_we   = 1'b0;
    mem_addr = pix_addr;
    unique case (state_q)
      S_CLEAR: begin
        mem_en   = 1'b1;
        mem_we   = 1'b1;
        mem_addr = clr_addr_q;
      end
      S_IDLE: mem_en = pix_acc && pix_in_range;
      S_ACC: begin
        mem_en   = in_range_q;
        mem_we   = in_range_q;
        mem_addr = addr_q;
      end
      default: ;
    endcase
  end

  mlsc_frame_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_frame_ram (
    .clk_i   (clk_i),
    .en_i    (mem_en),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i ((state_q == S_CLEAR) ? '0 : val_d),
    .rdata_o (mem_rdata)
  );

  // Leaky integrator: align input product to 32 fraction bits, floor to 8.16
  assign acc    = {1'b0, prod_in_q, 8'b0} + {1'b0, prod_lk_q};
  assign acc_r  = acc[ACC_W-1:COEF_W];
  assign val_d  = !mask_q ? '0
                : (acc_r > R_W'(VAL_MAX)) ? VAL_MAX : acc_r[VAL_W-1:0];
  assign detect = in_range_q && (val_d > {detect_thr_q, 8'b0});

  // Payload stages
  always_ff @(posedge clk_i) begin
    if (pix_acc) begin
      addr_q     <= pix_addr;
      x_q        <= pixel_i.pixel_x;
      y_q        <= pixel_i.pixel_y;
      m_q        <= (pixel_i.motion_salience > motion_sat_q) ? motion_sat_q
                                                             : pixel_i.motion_salience;
      mask_q     <= pixel_i.color_salience > color_thr_q;
      in_range_q <= pix_in_range;
      fend_q     <= pixel_i.frame_end;
    end
    if (state_q == S_MUL) begin
      prod_in_q <= PI_W'(m_q) * PI_W'(gain_q);
      prod_lk_q <= PL_W'(leak_q) * PL_W'(mem_rdata);
    end
    if (state_q == S_ACC) begin
      sal_q <= in_range_q ? val_d[VAL_W-1:VAL_W-SAL_W] : '0;
    end
  end

  // Detection count and coordinate sums, saturating
  assign sumx_inc = (SUMX_W + 1)'(sumx_q) + (SUMX_W + 1)'(x_q);
  assign sumy_inc = (SUMY_W + 1)'(sumy_q) + (SUMY_W + 1)'(y_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      sumx_q <= '0;
      sumy_q <= '0;
    end else if (state_q == S_DIV && cen_done) begin
      cnt_q  <= '0;
      sumx_q <= '0;
      sumy_q <= '0;
    end else if (state_q == S_ACC && detect) begin
      cnt_q  <= (&cnt_q) ? cnt_q : cnt_q + 1'b1;
      sumx_q <= sumx_inc[SUMX_W] ? '1 : sumx_inc[SUMX_W-1:0];
      sumy_q <= sumy_inc[SUMY_W] ? '1 : sumy_inc[SUMY_W-1:0];
    end
  end

  mlsc_centroid u_centroid (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cen_start_q),
    .count_i    (cnt_q),
    .sumx_i     (sumx_q),
    .sumy_i     (sumy_q),
    .min_jump_i (min_jump_q),
    .done_o     (cen_done),
    .cen_o      (cen)
  );

  // Load the output register when it is empty or being taken
  assign out_load = (state_q == S_OUT) && (!out_vld_q || result_o.ready);

  // Sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_addr_q  <= '0;
      cen_start_q <= 1'b0;
      out_vld_q   <= 1'b0;
      out_sal_q   <= '0;
      out_cen_q   <= '0;
    end else begin
      cen_start_q <= (state_q == S_ACC) && fend_q;
      if (out_load) begin
        out_vld_q <= 1'b1;
        out_sal_q <= sal_q;
        out_cen_q <= fend_q ? cen : '0;
      end else if (result_o.ready) begin
        out_vld_q <= 1'b0;
      end
      unique case (state_q)
        S_CLEAR: begin
          clr_addr_q <= clr_addr_q + 1'b1;
          if (clr_addr_q == AW'(DEPTH - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (pix_acc) begin
            state_q <= S_MUL;
          end
        end
        S_MUL: state_q <= S_ACC;
        S_ACC: begin
          if (fend_q) begin
            state_q <= S_DIV;
          end else begin
            state_q <= S_OUT;
          end
        end
        S_DIV: begin
          if (cen_done) begin
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          // hold the item until the output register is free
          if (out_load) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign result_o.valid             = out_vld_q;
  assign result_o.salience_out      = out_sal_q;
  assign result_o.centroid_valid    = out_cen_q.vld;
  assign result_o.centroid_reported = out_cen_q.rep;
  assign result_o.centroid_x        = out_cen_q.x;
  assign result_o.centroid_y        = out_cen_q.y;

  // Out-of-frame pixels never touch the RAM
  a_no_oob_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ACC) && !in_range_q |-> !mem_we)
    else $error("write-back for a pixel outside the frame");

  a_start_on_fend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cen_start_q |-> fend_q && (state_q == S_DIV))
    else $error("centroid started without a frame end");

  a_sums_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) && cen_done |=> (cnt_q == '0) && (sumx_q == '0) && (sumy_q == '0))
    else $error("frame sums not cleared after centroid");

  a_report_needs_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_cen_q.rep |-> out_cen_q.vld)
    else $error("centroid reported without detections");

endmodule
